// ===== rtl/core/asvr_pkg.sv =====
// Shared types, constants and helper functions for the ADC voltage report core.
// No dependencies; imported by every module of the core.
package asvr_pkg;

	localparam int GAIN_W     = 20;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd77860;
	localparam int FRAC_SHIFT = 16;
	localparam int CV_W       = 14;
	localparam logic [CV_W-1:0] CV_MAX = 14'd9999;
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = 3;
	localparam int QCNT_W     = 4;
	localparam int IDX_W      = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = 4'd11;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [3:0] CH_DIGIT_HI = 4'h3;

	localparam logic [3:0] IDX_A     = 4'd0;
	localparam logic [3:0] IDX_D     = 4'd1;
	localparam logic [3:0] IDX_C     = 4'd2;
	localparam logic [3:0] IDX_COLON = 4'd3;
	localparam logic [3:0] IDX_SPACE = 4'd4;
	localparam logic [3:0] IDX_D3    = 4'd5;
	localparam logic [3:0] IDX_D2    = 4'd6;
	localparam logic [3:0] IDX_POINT = 4'd7;
	localparam logic [3:0] IDX_D1    = 4'd8;
	localparam logic [3:0] IDX_D0    = 4'd9;
	localparam logic [3:0] IDX_LF    = 4'd10;
	localparam logic [3:0] IDX_CR    = 4'd11;

	typedef struct packed {
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} digits_t;

	typedef struct packed {
		logic    valid;
		digits_t digits;
	} qpush_t;

	typedef struct packed {
		logic [3:0]      digit;
		logic [CV_W-1:0] rem;
	} dstep_t;

	// one decimal digit by parallel compares against unit multiples
	function automatic dstep_t div_step(input logic [CV_W-1:0] v,
	                                    input logic [CV_W-1:0] unit);
		dstep_t r;
		logic [3:0] d;
		d = '0;
		for (int k = 1; k < 10; k++) begin
			if (v >= CV_W'(k) * unit) d = 4'(k);
		end
		r.digit = d;
		r.rem   = v - CV_W'(d) * unit;
		return r;
	endfunction

	function automatic logic [7:0] report_char(input logic [IDX_W-1:0] idx,
	                                          input digits_t dg);
		logic [7:0] c;
		case (idx)
			IDX_A:     c = CH_A;
			IDX_D:     c = CH_D;
			IDX_C:     c = CH_C;
			IDX_COLON: c = CH_COLON;
			IDX_SPACE: c = CH_SPACE;
			IDX_D3:    c = {CH_DIGIT_HI, dg.d3};
			IDX_D2:    c = {CH_DIGIT_HI, dg.d2};
			IDX_POINT: c = CH_POINT;
			IDX_D1:    c = {CH_DIGIT_HI, dg.d1};
			IDX_D0:    c = {CH_DIGIT_HI, dg.d0};
			IDX_LF:    c = CH_LF;
			IDX_CR:    c = CH_CR;
			default:   c = CH_CR;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/adc_sample_voltage_ascii_report_core.sv =====
// ADC sample voltage report core. Each accepted sample is scaled to centivolts,
// (sample * gain + 32768) >> 16 saturated to 9999, and reported as the twelve
// characters "ADC: dd.dd\n\r", one per cycle, with last_char set on the '\r'.
// The output side sustains one character per cycle while pop is held high; the
// character sequencer reading the digit queue head sets the pace of the reports.
// Up to 8 samples are taken back to back before full rises. Each sample passes
// the front pipeline, the digit queue and then the output register.
// The gain register resets to 77860 and cfg_ready is always high.
module adc_sample_voltage_ascii_report_core
	import asvr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   pop,
	output logic                   empty,
	output logic [7:0]             out_char,
	output logic                   last_char,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [GAIN_W-1:0]      cfg_data
);

	logic [GAIN_W-1:0] gain_q;
	qpush_t            qpush;
	logic              qpop;
	logic              qvalid;
	digits_t           qhead;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	asvr_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.gain      (gain_q),
		.credit_ret(qpop),
		.qpush     (qpush)
	);

	asvr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.qpush (qpush),
		.qpop  (qpop),
		.qvalid(qvalid),
		.qhead (qhead)
	);

	asvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qvalid   (qvalid),
		.qhead    (qhead),
		.qpop     (qpop),
		.pop      (pop),
		.empty    (empty),
		.out_char (out_char),
		.last_char(last_char)
	);

endmodule

// ===== rtl/core/asvr_front.sv =====
// Front end: accepts samples, scales to centivolts and splits into decimal digits.
// Five-stage pipeline with credit counting against the digit queue. Uses asvr_pkg.
module asvr_front
	import asvr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [GAIN_W-1:0]      gain,
	input  logic                   credit_ret,
	output qpush_t                 qpush
);

	localparam int PROD_W = SAMPLE_BITS + GAIN_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - FRAC_SHIFT;
	localparam int CMP_W  = (RND_W > CV_W) ? RND_W : CV_W;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

	logic                  accept;
	logic [QCNT_W-1:0]     cnt_q;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PROD_W-1:0]     prod_s1;
	logic [CV_W-1:0]       cv_s2;
	logic [3:0]            d3_s3, d3_s4, d3_s5;
	logic [9:0]            rem_s3;
	logic [3:0]            d2_s4, d2_s5;
	logic [6:0]            rem_s4;
	logic [3:0]            d1_s5, d0_s5;
	logic [SUM_W-1:0]      sum;
	logic [CMP_W-1:0]      rnd;
	dstep_t                st3, st4, st5;

	assign accept = push && !full;
	assign full   = (cnt_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({accept, credit_ret})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign sum = SUM_W'(prod_s1) + ROUND_HALF;
	assign rnd = CMP_W'(sum[SUM_W-1:FRAC_SHIFT]);
	assign st3 = div_step(cv_s2, 14'd1000);
	assign st4 = div_step(CV_W'(rem_s3), 14'd100);
	assign st5 = div_step(CV_W'(rem_s4), 14'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(sample) * PROD_W'(gain);
		cv_s2   <= (rnd > CMP_W'(CV_MAX)) ? CV_MAX : rnd[CV_W-1:0];
		d3_s3   <= st3.digit;
		rem_s3  <= st3.rem[9:0];
		d3_s4   <= d3_s3;
		d2_s4   <= st4.digit;
		rem_s4  <= st4.rem[6:0];
		d3_s5   <= d3_s4;
		d2_s5   <= d2_s4;
		d1_s5   <= st5.digit;
		d0_s5   <= st5.rem[3:0];
	end

	assign qpush.valid     = v_s5;
	assign qpush.digits.d3 = d3_s5;
	assign qpush.digits.d2 = d2_s5;
	assign qpush.digits.d1 = d1_s5;
	assign qpush.digits.d0 = d0_s5;

endmodule

// ===== rtl/core/asvr_queue.sv =====
// Short digit queue between front and back ends.
// Circular buffer of QDEPTH entries; depth bounded by front credits. Uses asvr_pkg.
module asvr_queue
	import asvr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  qpush_t  qpush,
	input  logic    qpop,
	output logic    qvalid,
	output digits_t qhead
);

	digits_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qvalid = (cnt_q != '0);
	assign qhead  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qpush.valid) mem_q[wr_ptr_q] <= qpush.digits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qpush.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (qpop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({qpush.valid, qpop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/asvr_back.sv =====
// Back end: character sequencer emitting the twelve-character report per queue entry.
// Drives the output register; pops the queue on the final character. Uses asvr_pkg.
module asvr_back
	import asvr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       qvalid,
	input  digits_t    qhead,
	output logic       qpop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       last_char
);

	logic             out_v_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic [IDX_W-1:0] idx_q;
	logic             advance;
	logic             emit;

	assign advance   = !out_v_q || pop;
	assign emit      = advance && qvalid;
	assign qpop      = emit && (idx_q == LAST_IDX);
	assign empty     = !out_v_q;
	assign out_char  = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) out_v_q <= qvalid;
			if (emit) idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= report_char(idx_q, qhead);
			last_q <= (idx_q == LAST_IDX);
		end
	end

endmodule

// ===== rtl/core/asvr_checker.sv =====
// Port-level checker for the ADC voltage report core, bound to the top level.
// Depends on asvr_pkg for character codes.
module asvr_checker
	import asvr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [7:0] out_char,
	input logic       last_char
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
		else $error("result changed while stalled");

	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_char == (out_char == CH_CR)))
		else $error("last_char not on carriage return");

	a_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_char) |=> (empty || out_char == CH_A))
		else $error("report line does not start with A");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_char) |=> !empty)
		else $error("gap inside a report line");

endmodule

bind adc_sample_voltage_ascii_report_core asvr_checker u_asvr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pop      (pop),
	.empty    (empty),
	.out_char (out_char),
	.last_char(last_char)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for adc_sample_voltage_ascii_report_core: random and directed samples, gain
// updates between phases, predicted report lines checked char by char. Needs asvr_pkg.

typedef struct {
	logic [7:0] ch;
	logic       last;
} report_char_t;

class report_scoreboard;
	logic [asvr_pkg::GAIN_W-1:0] gain;
	report_char_t                expected_chars[$];
	int                          errors;

	function new();
		gain = asvr_pkg::GAIN_RESET;
		errors = 0;
	endfunction

	// scale to centivolts, saturate, and queue the twelve report characters
	function void note_sample(input logic [9:0] s);
		logic [63:0] scaled;
		int unsigned cv;
		logic [7:0] line[12];
		report_char_t rc;
		scaled = (64'(s) * 64'(gain) + 64'd32768) >> 16;
		cv = (scaled > 64'd9999) ? 9999 : int'(scaled);
		line = '{"A", "D", "C", ":", " ",
			8'h30 + 8'((cv / 1000) % 10), 8'h30 + 8'((cv / 100) % 10), ".",
			8'h30 + 8'((cv / 10) % 10), 8'h30 + 8'(cv % 10), 8'h0A, 8'h0D};
		for (int k = 0; k < 12; k++) begin
			rc.ch = line[k];
			rc.last = (k == 11);
			expected_chars.push_back(rc);
		end
	endfunction

	function void check_char(input logic [7:0] ch, input logic last);
		report_char_t exp_rc;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected char transfer: got char %h last %b", $time, ch, last);
			errors++;
			return;
		end
		exp_rc = expected_chars.pop_front();
		if (ch !== exp_rc.ch) begin
			$display("%0t: out_char mismatch: expected %h, got %h", $time, exp_rc.ch, ch);
			errors++;
		end
		if (last !== exp_rc.last) begin
			$display("%0t: last_char mismatch: expected %b, got %b", $time, exp_rc.last, last);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 60;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic [9:0]                  sample;
	logic                        pop = 1'b0;
	logic                        empty;
	logic [7:0]                  out_char;
	logic                        last_char;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [asvr_pkg::GAIN_W-1:0] cfg_data;

	report_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_tog = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	adc_sample_voltage_ascii_report_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result side: check each transfer, then decide pop for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_char(out_char, last_char);
			if (hold_tog != hold_seen) begin
				hold_seen <= hold_tog;
				hold_left <= HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_sample(input logic [9:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			sample <= 10'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		do @(posedge clk); while (full);
		sb.note_sample(s);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [asvr_pkg::GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= asvr_pkg::GAIN_W'($urandom);
		sb.gain = g;
	endtask

	function automatic logic [9:0] rand_sample();
		logic [9:0] edges[4] = '{10'd0, 10'd1, 10'd1022, 10'd1023};
		if ($urandom_range(9) == 0)
			return edges[$urandom_range(3)];
		return 10'($urandom);
	endfunction

	initial begin
		logic [9:0] reset_set[9] = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1022,
			10'd1023, 10'h2AA, 10'h155};
		logic [asvr_pkg::GAIN_W-1:0] phase_gain[5];
		int idle_send[5] = '{0, 63, 0, 12, 0};
		int idle_recv[5] = '{0, 0, 63, 12, 0};

		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gain
		foreach (reset_set[i]) send_sample(reset_set[i]);
		drain();
		// zero gain
		write_gain('0);
		send_sample(10'd1023);
		send_sample(10'd777);
		drain();
		// max gain: saturation and its boundary
		write_gain('1);
		send_sample(10'd1023);
		send_sample(10'd625);
		send_sample(10'd624);
		send_sample(10'd0);
		drain();
		// rounding carry into the integer digits, also at a gain one step lower
		write_gain(20'd815232);
		send_sample(10'd8);
		send_sample(10'd4);
		drain();
		write_gain(20'd815231);
		send_sample(10'd8);
		drain();

		phase_gain = '{asvr_pkg::GAIN_RESET, asvr_pkg::GAIN_W'($urandom),
			asvr_pkg::GAIN_W'($urandom_range(100000, 60000)), '1,
			asvr_pkg::GAIN_W'($urandom_range(200000, 0))};
		for (int p = 0; p < 5; p++) begin
			write_gain(phase_gain[p]);
			send_idle_pct = idle_send[p];
			recv_stall_pct = idle_recv[p];
			if (p == 4)
				hold_tog <= ~hold_tog;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2)
					drain();
				send_sample(rand_sample());
			end
			drain();
		end

		if (sb.errors == 0 && sb.expected_chars.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== adc_sample_voltage_ascii_report_core.f =====
rtl/core/asvr_pkg.sv
rtl/core/asvr_front.sv
rtl/core/asvr_queue.sv
rtl/core/asvr_back.sv
rtl/core/adc_sample_voltage_ascii_report_core.sv
rtl/core/asvr_checker.sv
tb/tb.sv
